FILE: hdl/http_chunked_body_decoder_defines.svh
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/hcbd_pkg.sv
// Shared constants, types and helpers of the chunked body decoder.
package hcbd_pkg;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // One result beat as produced by the parser.
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       is_last;
   } result_type;

   // Hex digit decode: {is_digit, value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0_0000;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

FILE: hdl/hcbd_parser.sv
// Byte-at-a-time chunk framing parser: state registers and next-state logic.
`include "http_chunked_body_decoder_defines.svh"

module hcbd_parser #(
   parameter int SIZE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   input  logic                  restart,
   output hcbd_pkg::result_type  result
);
   import hcbd_pkg::*;

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   hex_value_ff, hex_value_in;
   logic                   digits_closed_ff, digits_closed_in;
   logic                   line_nonblank_ff, line_nonblank_in;
   logic                   cr_pending_ff, cr_pending_in;
   logic [SIZE_BITS-1:0]   bytes_left_ff, bytes_left_in;

   // state as seen by this beat, after an optional restart
   phase_type              ph;
   logic [SIZE_BITS-1:0]   hex_cur;
   logic                   closed_cur;
   logic                   nonblank_cur;
   logic                   crp_cur;
   logic [SIZE_BITS-1:0]   left_cur;
   logic [4:0]             dig;

   always_comb begin
      ph           = restart ? PH_SIZE : phase_ff;
      hex_cur      = restart ? '0 : hex_value_ff;
      closed_cur   = restart ? 1'b0 : digits_closed_ff;
      nonblank_cur = restart ? 1'b0 : line_nonblank_ff;
      crp_cur      = restart ? 1'b0 : cr_pending_ff;
      left_cur     = restart ? '0 : bytes_left_ff;
      dig          = hex_digit(in_byte);

      phase_in         = ph;
      hex_value_in     = hex_cur;
      digits_closed_in = closed_cur;
      line_nonblank_in = nonblank_cur;
      cr_pending_in    = crp_cur;
      bytes_left_in    = left_cur;
      result           = '{valid: 1'b0, data_byte: 8'h00, is_last: 1'b0};

      unique case (ph)
         PH_DATA: begin
            result        = '{valid: 1'b1, data_byte: in_byte, is_last: 1'b0};
            bytes_left_in = left_cur - 1'b1;
            if (left_cur == SIZE_BITS'(1)) begin
               phase_in         = PH_SIZE;
               hex_value_in     = '0;
               digits_closed_in = 1'b0;
               line_nonblank_in = 1'b0;
               cr_pending_in    = 1'b0;
            end
         end
         PH_SIZE: begin
            if (in_byte == CHAR_LF) begin
               hex_value_in     = '0;
               digits_closed_in = 1'b0;
               line_nonblank_in = 1'b0;
               cr_pending_in    = 1'b0;
               if (nonblank_cur) begin
                  if (hex_cur == '0) begin
                     phase_in = PH_DONE;
                     result   = '{valid: 1'b1, data_byte: 8'h00, is_last: 1'b1};
                  end else begin
                     phase_in      = PH_DATA;
                     bytes_left_in = hex_cur;
                  end
               end
            end else begin
               // a held CR not followed by LF is plain non-hex content
               if (crp_cur) begin
                  line_nonblank_in = 1'b1;
                  digits_closed_in = 1'b1;
                  cr_pending_in    = 1'b0;
               end
               if (in_byte == CHAR_CR) begin
                  cr_pending_in = 1'b1;
               end else begin
                  line_nonblank_in = 1'b1;
                  if (!digits_closed_in) begin
                     if (!dig[4]) begin
                        digits_closed_in = 1'b1;
                     end else if (hex_cur[SIZE_BITS-1 -: 4] != 4'h0) begin
                        hex_value_in = '1;
                     end else begin
                        hex_value_in = {hex_cur[SIZE_BITS-5:0], dig[3:0]};
                     end
                  end
               end
            end
         end
         default: begin
            // done: swallow bytes until restart
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SIZE;
         hex_value_ff     <= '0;
         digits_closed_ff <= 1'b0;
         line_nonblank_ff <= 1'b0;
         cr_pending_ff    <= 1'b0;
         bytes_left_ff    <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         hex_value_ff     <= hex_value_in;
         digits_closed_ff <= digits_closed_in;
         line_nonblank_ff <= line_nonblank_in;
         cr_pending_ff    <= cr_pending_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

   `HCBD_ASSERT_NOW(a_data_has_count, clock, reset, phase_ff == PH_DATA, bytes_left_ff != '0, "data phase with zero bytes left")
   `HCBD_ASSERT_NEXT(a_last_ends_body, clock, reset, step && result.valid && result.is_last, phase_ff == PH_DONE, "last beat did not end the body")
   `HCBD_ASSERT_NOW(a_digits_need_content, clock, reset, digits_closed_ff, line_nonblank_ff || cr_pending_ff, "digit run closed on an empty line")

endmodule

FILE: hdl/http_chunked_body_decoder.sv
// Chunked body decoder: one raw body byte per beat in, payload bytes out.
// Takes one raw byte per clock and updates the chunk parser in that same cycle;
// each byte yields at most one result beat, held in a single output register.
// A new byte is accepted in every cycle unless that register is full and
// stalled. Chunk data bytes come out one beat per byte; the zero-size line
// gives one beat with rsp_is_last set and a zero byte, after which input is
// swallowed until a beat with req_restart set. No clearing pass after reset.
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder #(
   parameter int SIZE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_is_last
);
   import hcbd_pkg::*;

   logic       accept;
   result_type result;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_byte_ff;
   logic       rsp_is_last_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   hcbd_parser #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .in_byte (req_in_byte),
      .restart (req_restart),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         rsp_data_byte_ff <= result.data_byte;
         rsp_is_last_ff   <= result.is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_byte_ff;
   assign rsp_is_last   = rsp_is_last_ff;

   `HCBD_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid_ff, "input stalled with output register empty")
   `HCBD_ASSERT_NOW(a_last_is_zero, clock, reset, rsp_valid_ff && rsp_is_last_ff, rsp_data_byte_ff == 8'h00, "last beat carries nonzero byte")
   `HCBD_ASSERT_NEXT(a_held_beat_stays, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff, "stalled result beat dropped")

endmodule

FILE: verif/tb_http_chunked_body_decoder.sv
// Self-checking testbench for the HTTP chunked body decoder: random bodies, stalls and gaps.
module tb_http_chunked_body_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import hcbd_pkg::*;

   localparam int SIZE_BITS = 32;
   localparam logic [35:0] SIZE_MAX = (36'd1 << SIZE_BITS) - 36'd1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES = 16;
   localparam int RANDOM_BEATS = 1100;

   localparam logic [1:0] PH_SIZE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_type;

   typedef struct {
      logic [7:0] in_byte;
      logic       restart;
      bit         hold;     // wait for all results to drain before sending
   } body_beat_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } payload_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_restart = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_is_last;

   body_beat_type    stim_q[$];
   payload_beat_type payload_q[$];

   int pending_count = 0;
   int beats_taken = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int ignored_beats = 0;
   bit next_restart = 1'b0;
   bit next_hold = 1'b0;

   // Decoder state mirrored by the predictor
   logic [1:0]  sz_phase;
   logic [31:0] size_acc;
   bit          digits_done;
   bit          line_has_content;
   bit          cr_held;
   logic [31:0] data_left;

   http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_is_last   (rsp_is_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic int hex_val(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   function automatic void clear_size_line();
      size_acc = '0;
      digits_done = 1'b0;
      line_has_content = 1'b0;
      cr_held = 1'b0;
   endfunction

   function automatic void size_line_char(input logic [7:0] c);
      int d;
      logic [35:0] wide;
      d = hex_val(c);
      line_has_content = 1'b1;
      if (digits_done) return;
      if (d < 0) begin
         digits_done = 1'b1;
         return;
      end
      wide = {size_acc, 4'(d)};
      size_acc = (wide > SIZE_MAX) ? SIZE_MAX[31:0] : wide[31:0];
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic rs,
                                      output logic [7:0] d, output logic last);
      d = 8'h00;
      last = 1'b0;
      if (rs) begin
         sz_phase = PH_SIZE;
         data_left = '0;
         clear_size_line();
      end
      if (sz_phase == PH_DATA) begin
         d = b;
         data_left = data_left - 1;
         if (data_left == 0) begin
            sz_phase = PH_SIZE;
            clear_size_line();
         end
         return 1'b1;
      end
      if (sz_phase != PH_SIZE) return 1'b0;
      if (b == CHAR_LF) begin
         // a CR held right before LF is dropped
         if (!line_has_content) begin
            clear_size_line();
            return 1'b0;
         end
         if (size_acc == 0) begin
            sz_phase = PH_DONE;
            clear_size_line();
            last = 1'b1;
            return 1'b1;
         end
         data_left = size_acc;
         sz_phase = PH_DATA;
         clear_size_line();
         return 1'b0;
      end
      if (cr_held) begin
         cr_held = 1'b0;
         size_line_char(CHAR_CR);
      end
      if (b == CHAR_CR) begin
         cr_held = 1'b1;
         return 1'b0;
      end
      size_line_char(b);
      return 1'b0;
   endfunction

   // ---------------- stimulus building ----------------

   task automatic add_byte(input logic [7:0] b);
      body_beat_type it;
      it.in_byte = b;
      it.restart = next_restart;
      it.hold = next_hold;
      next_restart = 1'b0;
      next_hold = 1'b0;
      stim_q.push_back(it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 10) return 8'h30 + nib;
      return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 10);
   endfunction

   task automatic add_eol();
      if ($urandom_range(0, 3) != 0) add_text("\r\n");
      else add_byte(CHAR_LF);
   endtask

   task automatic add_size_line(input logic [31:0] n);
      bit started;
      started = 1'b0;
      if ($urandom_range(0, 7) == 0) add_text("00");
      for (int i = 7; i >= 0; i--) begin
         if (n[i*4 +: 4] != 0 || started || i == 0) begin
            started = 1'b1;
            add_byte(hex_char(n[i*4 +: 4]));
         end
      end
      case ($urandom_range(0, 9))
         0: begin
            add_text(";ext=");
            add_byte(8'($urandom_range(0, 255)));
         end
         1: add_text(" ;x");
         2: add_text("\rq");        // CR not before LF ends the digits
         3: add_byte(CHAR_CR);      // CR, then CR LF or bare LF
         default: ;
      endcase
      add_eol();
   endtask

   function automatic int pick_chunk_size();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return $urandom_range(1, 8);
      if (r < 19) return $urandom_range(9, 32);
      return $urandom_range(33, 120);
   endfunction

   task automatic add_body();
      int kind;
      int n;
      int cnt;
      next_restart = 1'b1;
      if ($urandom_range(0, 5) == 0) next_hold = 1'b1;
      kind = $urandom_range(0, 11);
      case (kind)
         0: begin
            // raw noise, line ends included
            cnt = $urandom_range(4, 24);
            repeat (cnt) begin
               case ($urandom_range(0, 7))
                  0: add_byte(CHAR_LF);
                  1: add_byte(CHAR_CR);
                  default: add_byte(8'($urandom_range(0, 255)));
               endcase
            end
         end
         1: begin
            // size overflow, cut short by the next restart
            cnt = $urandom_range(9, 11);
            add_byte(hex_char(4'($urandom_range(1, 15))));
            repeat (cnt - 1) add_byte(hex_char(4'($urandom_range(0, 15))));
            add_eol();
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
         end
         2: begin
            // truncated chunk
            n = $urandom_range(4, 20);
            add_size_line(n);
            repeat ($urandom_range(0, n - 1)) add_byte(8'($urandom_range(0, 255)));
         end
         3: begin
            // no leading digit ends the body
            case ($urandom_range(0, 2))
               0: add_text("zz");
               1: add_text("\rX5");
               default: add_byte(8'($urandom_range(0, 31)));
            endcase
            add_eol();
            cnt = $urandom_range(0, 4);
            repeat (cnt) add_byte(8'($urandom_range(0, 255)));
            ignored_beats += cnt;
         end
         default: begin
            if ($urandom_range(0, 3) == 0) add_text("\r\n\n");
            repeat ($urandom_range(1, 5)) begin
               n = pick_chunk_size();
               add_size_line(n);
               repeat (n) add_byte(8'($urandom_range(0, 255)));
               if ($urandom_range(0, 7) != 0) add_eol();
            end
            add_size_line(0);
            cnt = $urandom_range(0, 4);
            repeat (cnt) add_byte(8'($urandom_range(0, 255)));
            ignored_beats += cnt;
         end
      endcase
   endtask

   // ---------------- driver ----------------

   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      body_beat_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (stim_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (stim_q[0].hold && (req_valid || pending_count != 0)) begin
            req_valid <= 1'b0;
         end else begin
            it = stim_q.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= it.in_byte;
            req_restart <= it.restart;
            if (burst_left <= 1) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 24);
            end else begin
               burst_left = burst_left - 1;
            end
         end
      end
   end

   // ---------------- receiver stall ----------------

   stall_mode_type stall_mode = STALL_NONE;
   int mode_left = 0;
   int stall_tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left <= 100;
      end else begin
         stall_tick <= stall_tick + 1;
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(50, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_tick % 7 >= 4);
            default:        rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
         endcase
      end
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin : monitor
      logic [7:0] want_byte;
      logic want_last;
      payload_beat_type want;
      bit moved;
      if (reset) begin
         sz_phase = PH_SIZE;
         data_left = '0;
         clear_size_line();
         payload_q.delete();
         pending_count <= 0;
         idle_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            beats_taken <= beats_taken + 1;
            if (decode_byte(req_in_byte, req_restart, want_byte, want_last))
               payload_q.push_back(payload_beat_type'{data_byte: want_byte,
                                                      is_last: want_last});
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (payload_q.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected result beat: data_byte=%02h is_last=%0d",
                           rsp_data_byte, rsp_is_last);
            end else begin
               want = payload_q.pop_front();
               if (rsp_data_byte !== want.data_byte || rsp_is_last !== want.is_last) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display({"mismatch: expected data_byte=%02h is_last=%0d,",
                               " got data_byte=%02h is_last=%0d"},
                              want.data_byte, want.is_last, rsp_data_byte, rsp_is_last);
               end
            end
         end
         pending_count <= payload_q.size();
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int total_beats;
      bit timed_out;
      timed_out = 1'b0;

      // directed: data-phase CR and 0xFF, blank line, CR not before LF,
      // LF as payload, saturating size, NUL-only line, done phase
      next_restart = 1'b1;
      add_text("2\n");
      add_byte(8'hFF);
      add_byte(CHAR_CR);
      add_text("\r\n1\ra\n");
      add_byte(CHAR_LF);
      add_text("100000000\r\n");
      add_byte(8'h00);
      add_byte(8'h80);
      next_restart = 1'b1;
      add_byte(8'h00);
      add_byte(CHAR_LF);
      add_text("7");
      ignored_beats += 1;

      add_body();
      stim_q[27].hold = 1'b1;   // first random body waits for drain
      while (stim_q.size() - ignored_beats < RANDOM_BEATS + 27) add_body();
      total_beats = stim_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!(beats_taken == total_beats && pending_count == 0)) begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
      end
      if (!timed_out) repeat (TAIL_CYCLES) @(posedge clock);

      if (timed_out || mismatches != 0 || pending_count != 0) begin
         $display("tb: failure");
      end else begin
         $display("tb: success");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_parser.sv
hdl/http_chunked_body_decoder.sv
verif/tb_http_chunked_body_decoder.sv
